[hdl/left_neighbour_dpcm_codec_defines.svh]
// Assertion helpers for the checker file.
// Each macro expects the clock to be named clk and the reset rst_n in the scope where it is used.
`ifndef LEFT_NEIGHBOUR_DPCM_CODEC_DEFINES_SVH
`define LEFT_NEIGHBOUR_DPCM_CODEC_DEFINES_SVH

// Check an implication in the same cycle (or with explicit ## delays inside prop).
`define LNDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define LNDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lndc_pkg.sv]
package lndc_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int MAX_LINE   = 4096;

    localparam int DATA_W     = MAX_DEPTH;
    localparam int DEPTH_W    = 5;
    localparam int LINE_W     = 13;
    localparam int COL_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 2'd2;

    // Reset values
    localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST  = 5'd8;
    localparam logic [LINE_W-1:0]  LINE_WIDTH_RST = 13'd640;

    // Effective configuration as seen by the datapath
    typedef struct packed {
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] half;
        logic [LINE_W-1:0] width;
        logic              inverse;
    } cfg_t;

endpackage

[hdl/left_neighbour_dpcm_codec.sv]
// Left-neighbour DPCM codec, one sample per request in raster order. Each sample passes an
// input register and an output register, where its result is captured as the request advances,
// and one request is taken every cycle while the output is not stalled. The predictor
// is zero at a plane start, the sample above at column 0 of later rows, and the left
// neighbour elsewhere; forward mode emits (sample - pred + half) mod 2^depth, inverse mode
// emits (pred + residual - half) mod 2^depth. Depth and line width are clamped to 1..16 and
// 1..4096. Write configuration only while no request is in flight.
module left_neighbour_dpcm_codec
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lndc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lndc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lndc_pkg::DATA_W-1:0]      sample_in,
    input  logic                             plane_start,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lndc_pkg::DATA_W-1:0]      sample_out
);

    lndc_pkg::cfg_t cfg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [lndc_pkg::DATA_W-1:0] s1_sample_reg;
    logic                        s1_start_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lndc_pkg::DATA_W-1:0] out_sample_reg;
    logic [lndc_pkg::DATA_W-1:0] result;
    logic                        accept;
    logic                        advance;

    lndc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lndc_predictor u_pred
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (s1_sample_reg),
        .start   (s1_start_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move the held request forward whenever the output slot is free or being taken
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in;
            s1_start_reg  <= plane_start;
        end
        if (advance)
        begin
            out_sample_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;

endmodule

[hdl/lndc_cfg_regs.sv]
module lndc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lndc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lndc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lndc_pkg::cfg_t                   cfg
);

    logic [lndc_pkg::DEPTH_W-1:0] depth_reg;
    logic [lndc_pkg::LINE_W-1:0]  width_reg;
    logic                         inverse_reg;
    logic [lndc_pkg::DEPTH_W-1:0] depth_eff;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= lndc_pkg::BIT_DEPTH_RST;
            width_reg   <= lndc_pkg::LINE_WIDTH_RST;
            inverse_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lndc_pkg::REG_BIT_DEPTH:
                begin
                    depth_reg <= cfg_data[lndc_pkg::DEPTH_W-1:0];
                end
                lndc_pkg::REG_LINE_WIDTH:
                begin
                    width_reg <= cfg_data[lndc_pkg::LINE_W-1:0];
                end
                lndc_pkg::REG_INVERSE_MODE:
                begin
                    inverse_reg <= cfg_data[0];
                end
                default:
                begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Clamp depth and width into their legal ranges
    always_comb
    begin
        if (depth_reg == '0)
            depth_eff = lndc_pkg::DEPTH_W'(1);
        else if (depth_reg > lndc_pkg::DEPTH_W'(lndc_pkg::MAX_DEPTH))
            depth_eff = lndc_pkg::DEPTH_W'(lndc_pkg::MAX_DEPTH);
        else
            depth_eff = depth_reg;

        cfg.mask = lndc_pkg::DATA_W'(((lndc_pkg::DATA_W+1)'(1) << depth_eff)
                                     - (lndc_pkg::DATA_W+1)'(1));
        cfg.half = lndc_pkg::DATA_W'((lndc_pkg::DATA_W+1)'(1)
                                     << (depth_eff - lndc_pkg::DEPTH_W'(1)));

        if (width_reg == '0)
            cfg.width = lndc_pkg::LINE_W'(1);
        else if (width_reg > lndc_pkg::LINE_W'(lndc_pkg::MAX_LINE))
            cfg.width = lndc_pkg::LINE_W'(lndc_pkg::MAX_LINE);
        else
            cfg.width = width_reg;

        cfg.inverse = inverse_reg;
    end

endmodule

[hdl/lndc_predictor.sv]
module lndc_predictor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [lndc_pkg::DATA_W-1:0]    sample,
    input  logic                           start,
    input  lndc_pkg::cfg_t                 cfg,
    output logic [lndc_pkg::DATA_W-1:0]    result
);

    logic [lndc_pkg::DATA_W-1:0] left_reg;
    logic [lndc_pkg::DATA_W-1:0] left_next;
    logic [lndc_pkg::DATA_W-1:0] row_first_reg;
    logic [lndc_pkg::DATA_W-1:0] row_first_next;
    logic [lndc_pkg::COL_W-1:0]  col_reg;
    logic [lndc_pkg::COL_W-1:0]  col_next;
    logic                        first_row_reg;
    logic                        first_row_next;

    logic [lndc_pkg::COL_W-1:0]  col_cur;
    logic                        first_row_cur;
    logic [lndc_pkg::DATA_W-1:0] x;
    logic [lndc_pkg::DATA_W-1:0] pred;
    logic [lndc_pkg::LINE_W-1:0] col_inc;

    // Predict, code and work out the next position
    always_comb
    begin
        col_cur       = start ? '0 : col_reg;
        first_row_cur = start ? 1'b1 : first_row_reg;
        x             = sample & cfg.mask;

        if (col_cur == '0)
            pred = first_row_cur ? '0 : (row_first_reg & cfg.mask);
        else
            pred = left_reg & cfg.mask;

        if (cfg.inverse)
        begin
            left_next = (pred + x - cfg.half) & cfg.mask;
            result    = left_next;
        end
        else
        begin
            left_next = x;
            result    = (x - pred + cfg.half) & cfg.mask;
        end

        row_first_next = (col_cur == '0) ? left_next : row_first_reg;

        col_inc = lndc_pkg::LINE_W'(col_cur) + lndc_pkg::LINE_W'(1);
        if (col_inc >= cfg.width)
        begin
            col_next       = '0;
            first_row_next = 1'b0;
        end
        else
        begin
            col_next       = col_inc[lndc_pkg::COL_W-1:0];
            first_row_next = first_row_cur;
        end
    end

    // Advance the plane position on each coded sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            row_first_reg <= '0;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else if (advance)
        begin
            left_reg      <= left_next;
            row_first_reg <= row_first_next;
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

endmodule

[hdl/lndc_checker.sv]
`include "left_neighbour_dpcm_codec_defines.svh"

module lndc_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [lndc_pkg::DATA_W-1:0]      sample_out
);

    // A stalled result holds
    `LNDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")

    // Every accepted request is followed by a valid output
    `LNDC_ASSERT(a_latency, (in_valid && !in_stall) |-> ##2 out_valid, "accepted request produced no result")

    // An empty output never blocks the input
    `LNDC_ASSERT(a_no_false_stall, !out_valid |-> !in_stall, "input stalled with empty output")

    // Input only stalls when the output is backed up
    `LNDC_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without back pressure")

endmodule

bind left_neighbour_dpcm_codec lndc_checker u_lndc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);
